// File: hdl/hrol_pkg.sv
`default_nettype none
package hrol_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_MULT  = 32'd16777619;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_MEMBER = 2'd1;
  localparam logic [1:0] ACT_KEY    = 2'd2;

  localparam logic [1:0] ST_ADDED     = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FOUND     = 2'd2;
  localparam logic [1:0] ST_TOO_SMALL = 2'd3;

  typedef struct packed {
    logic clear;
    logic mix;
    logic finish;
  } fnv_ctl_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic is_key;
  } ring_cmd_t;

  typedef struct packed {
    logic       done;
    logic [1:0] status;
    logic [3:0] first;
    logic [3:0] second;
  } ring_resp_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [3:0]  member;
  } ring_entry_t;

endpackage
`default_nettype wire

// File: hdl/hash_ring_owner_lookup.sv
`default_nettype none
// Consistent-hash ring; strings are hashed with the 32-bit FNV-1a basis and
// prime, bytes sign-extended. Bytes of a member address (action 1) or key
// (action 2) are taken one per cycle into a shared 32x32 multiplier; action 0
// clears the ring, action 3 is dropped. The last byte of a string is followed
// by a closing multiply, the start of the ring walk, the walk itself and the
// hand-over and loading of the result. The ring table is a single-port-read
// memory of RING_SIZE entries: an insert moves each entry above the new hash
// up one place from the top, then writes the new entry below them (at once on
// an empty ring), and a lookup scans from entry 0 to the first entry whose
// hash is not below the key (wrapping to entry 0 after all entries), then
// reads that owner and the next. A rejected insert or a ring under two members
// answers at once. No request is taken while a string end is being processed.
module hash_ring_owner_lookup
  import hrol_pkg::*;
#(
  parameter int RING_SIZE = 16
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [3:0]  member_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  status,
  output logic      [3:0]  first_owner,
  output logic      [3:0]  second_owner,
  output logic      [31:0] string_hash
);

  typedef enum logic [2:0] {S_IDLE, S_FIN, S_START, S_WAIT, S_OUT} state_t;

  state_t      state;
  logic        accept;
  logic        is_key;
  logic [3:0]  mid;
  fnv_ctl_t    fctl;
  ring_cmd_t   rcmd;
  ring_resp_t  rresp;
  logic [31:0] fin_hash;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    fctl.clear  = accept && (action == ACT_CLEAR);
    fctl.mix    = accept && ((action == ACT_MEMBER) || (action == ACT_KEY));
    fctl.finish = (state == S_FIN);
    rcmd.clear  = fctl.clear;
    rcmd.start  = (state == S_START);
    rcmd.is_key = is_key;
  end

  hrol_fnv u_fnv (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fctl),
    .data_byte (data_byte),
    .fin_hash  (fin_hash)
  );

  hrol_ring #(.RING_SIZE(RING_SIZE)) u_ring (
    .clk       (clk),
    .rst       (rst),
    .cmd       (rcmd),
    .hash      (fin_hash),
    .member_id (mid),
    .resp      (rresp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (fctl.mix && last_byte) begin
            is_key <= (action == ACT_KEY);
            mid    <= member_id;
            state  <= S_FIN;
          end
        end
        S_FIN:   state <= S_START;
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (rresp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= rresp.status;
            first_owner  <= rresp.first;
            second_owner <= rresp.second;
            string_hash  <= fin_hash;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/hrol_fnv.sv
`default_nettype none
module hrol_fnv
  import hrol_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire fnv_ctl_t    ctl,
  input  wire logic [7:0]  data_byte,
  output logic      [31:0] fin_hash
);

  logic [31:0] running_hash;
  logic [31:0] ext;
  logic [31:0] mul_a;
  logic [31:0] prod;

  assign ext   = {{24{data_byte[7]}}, data_byte};
  assign mul_a = ctl.finish ? running_hash : (running_hash ^ ext);
  assign prod  = mul_a * FNV_MULT;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
    end else if (ctl.clear || ctl.finish) begin
      running_hash <= FNV_BASIS;
    end else if (ctl.mix) begin
      running_hash <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      fin_hash <= prod;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hrol_ring.sv
`default_nettype none
module hrol_ring
  import hrol_pkg::*;
#(
  parameter int RING_SIZE = 16
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ring_cmd_t   cmd,
  input  wire logic [31:0] hash,
  input  wire logic [3:0]  member_id,
  output ring_resp_t       resp
);

  localparam int IW = (RING_SIZE > 2) ? $clog2(RING_SIZE) : 1;
  localparam int CW = $clog2(RING_SIZE + 1);

  typedef enum logic [3:0] {
    R_IDLE, R_INS_RD, R_INS_CHK, R_INS_PUT,
    R_LK_RD, R_LK_CHK, R_O1_RD, R_O1, R_O2_RD, R_O2
  } rstate_t;

  rstate_t       state;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic [31:0]   key;
  logic [3:0]    mid;

  ring_entry_t   mem [RING_SIZE];
  ring_entry_t   rdata;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  ring_entry_t   wdata;
  logic [CW-1:0] idx_inc;

  assign idx_inc = CW'(idx) + CW'(1);

  always_comb begin
    raddr = idx;
    we    = 1'b0;
    waddr = idx;
    wdata = '{hash: key, member: mid};
    unique case (state)
      R_INS_RD: raddr = idx - IW'(1);
      R_O2_RD:  raddr = (idx_inc == count) ? '0 : idx_inc[IW-1:0];
      R_INS_CHK: begin
        we = 1'b1;
        if (rdata.hash > key) begin
          wdata = rdata;
        end
      end
      R_INS_PUT: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= R_IDLE;
      count     <= '0;
      resp.done <= 1'b0;
    end else begin
      resp.done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (cmd.clear) begin
            count <= '0;
          end else if (cmd.start) begin
            key         <= hash;
            mid         <= member_id;
            resp.first  <= '0;
            resp.second <= '0;
            if (!cmd.is_key) begin
              if (count == CW'(RING_SIZE)) begin
                resp.status <= ST_FULL;
                resp.done   <= 1'b1;
              end else begin
                idx   <= count[IW-1:0];
                state <= (count == '0) ? R_INS_PUT : R_INS_RD;
              end
            end else begin
              if (count < CW'(2)) begin
                resp.status <= ST_TOO_SMALL;
                resp.done   <= 1'b1;
              end else begin
                idx   <= '0;
                state <= R_LK_RD;
              end
            end
          end
        end
        R_INS_RD: state <= R_INS_CHK;
        R_INS_CHK: begin
          if (rdata.hash > key) begin
            idx   <= idx - IW'(1);
            state <= (idx == IW'(1)) ? R_INS_PUT : R_INS_RD;
          end else begin
            count       <= count + CW'(1);
            resp.status <= ST_ADDED;
            resp.done   <= 1'b1;
            state       <= R_IDLE;
          end
        end
        R_INS_PUT: begin
          count       <= count + CW'(1);
          resp.status <= ST_ADDED;
          resp.done   <= 1'b1;
          state       <= R_IDLE;
        end
        R_LK_RD: state <= R_LK_CHK;
        R_LK_CHK: begin
          if (key <= rdata.hash) begin
            state <= R_O1_RD;
          end else if (idx_inc == count) begin
            idx   <= '0;
            state <= R_O1_RD;
          end else begin
            idx   <= idx_inc[IW-1:0];
            state <= R_LK_RD;
          end
        end
        R_O1_RD: state <= R_O1;
        R_O1: begin
          resp.first <= rdata.member;
          state      <= R_O2_RD;
        end
        R_O2_RD: state <= R_O2;
        R_O2: begin
          resp.second <= rdata.member;
          resp.status <= ST_FOUND;
          resp.done   <= 1'b1;
          state       <= R_IDLE;
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
